// ===== src/magnetometer_axis_compensation_defines.svh =====
// Assertion macros shared by the compensation block.
`ifndef MAGNETOMETER_AXIS_COMPENSATION_DEFINES_SVH
`define MAGNETOMETER_AXIS_COMPENSATION_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define MC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define MC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mag_comp_pkg.sv =====
// Package with widths, gain constants and trim decoding for the compensation block.
`timescale 1ns / 1ps

package mag_comp_pkg;

   localparam int RawW    = 16;
   localparam int AxisW   = 17;
   localparam int GainW   = 21;
   localparam int ProdW   = 40;
   localparam int FieldXW = 26;
   localparam int FieldW  = 28;
   localparam int TrimW   = 8;
   localparam int CodeW   = 6;
   localparam int StepW   = 10;
   localparam int CsrIdxW = 1;
   localparam int DivShift = 10;

   localparam logic [GainW-1:0] GainX      = 21'd1000000;
   localparam logic [GainW-1:0] GainYReset = 21'd1000000;
   localparam logic [GainW-1:0] GainZReset = 21'd1350000;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_TRIM_LOW  = 1'b0,
      CSR_TRIM_HIGH = 1'b1
   } csr_index_type;

   // Signed trim step: codes of 32 and above count downward, six units a code.
   function automatic logic signed [StepW-1:0] trim_step(logic [CodeW-1:0] code);
      logic signed [StepW-1:0] c;
      logic signed [StepW-1:0] v;
      c = $signed({{(StepW-CodeW){1'b0}}, code});
      v = code[CodeW-1] ? (10'sd32 - c) : c;
      return v * 10'sd6;
   endfunction

   function automatic logic [GainW-1:0] gain_y_f(logic [CodeW-1:0] code);
      logic signed [GainW+1:0] g;
      g = 23'sd1000000 + 23'(trim_step(code)) * 23'sd1000;
      return g[GainW-1:0];
   endfunction

   function automatic logic [GainW-1:0] gain_z_f(logic [CodeW-1:0] code);
      logic signed [GainW+1:0] g;
      g = (23'(trim_step(code)) + 23'sd1000) * 23'sd1350;
      return g[GainW-1:0];
   endfunction

   function automatic logic [CodeW-1:0] code_z_f(logic [TrimW-1:0] low_byte,
                                                 logic [TrimW-1:0] high_byte);
      return {high_byte[3:0], low_byte[7:6]};
   endfunction

endpackage

// ===== src/mag_comp_if.sv =====
// Handshake interfaces for the request, result and register write channels.
`timescale 1ns / 1ps

interface mag_comp_req_if import mag_comp_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [RawW-1:0] raw_first;
   logic [RawW-1:0] raw_second;
   logic [RawW-1:0] raw_third;

   modport source (output valid, raw_first, raw_second, raw_third, input ready);
   modport sink   (input valid, raw_first, raw_second, raw_third, output ready);
endinterface

interface mag_comp_rsp_if import mag_comp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FieldXW-1:0] field_x;
   logic signed [FieldW-1:0]  field_y;
   logic signed [FieldW-1:0]  field_z;

   modport source (output valid, field_x, field_y, field_z, input ready);
   modport sink   (input valid, field_x, field_y, field_z, output ready);
endinterface

interface mag_comp_csr_if import mag_comp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CsrIdxW-1:0] index;
   logic [TrimW-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/magnetometer_axis_compensation.sv =====
// Top level of the magnetometer axis compensation block.
// An accepted word goes through stage one to the result register driving the result channel.
// One word per cycle unless rsp stalls; the gain multipliers sit between two register stages.
// A waiting result does not block the input while the first stage is empty.
// Reset is synchronous: it empties both stages and sets the trim bytes to zero,
// which gives gains of 1000000 for Y and 1350000 for Z.
`timescale 1ns / 1ps
`include "magnetometer_axis_compensation_defines.svh"

module magnetometer_axis_compensation
   import mag_comp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   mag_comp_req_if.sink   req_chan,
   mag_comp_rsp_if.source rsp_chan,
   mag_comp_csr_if.sink   csr_chan
);

   logic [TrimW-1:0]  trim_low_ff, trim_low_in;
   logic [TrimW-1:0]  trim_high_ff, trim_high_in;
   logic [GainW-1:0]  gain_y_ff, gain_y_in;
   logic [GainW-1:0]  gain_z_ff, gain_z_in;

   logic                     s1_valid_ff, s1_valid_in;
   logic signed [AxisW-1:0]  x_ff, y_ff, z_ff;
   logic signed [AxisW-1:0]  x_in, y_in, z_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [FieldXW-1:0] field_x_ff;
   logic signed [FieldW-1:0]  field_y_ff, field_z_ff;
   logic signed [FieldW-1:0]  scaled_x, scaled_y, scaled_z;

   logic req_accept;
   logic csr_accept;
   logic out_free;
   logic s1_move;

   assign csr_chan.ready = 1'b1;
   assign csr_accept     = csr_chan.valid && csr_chan.ready;

   always_comb begin
      trim_low_in  = trim_low_ff;
      trim_high_in = trim_high_ff;
      if (csr_accept) begin
         case (csr_index_type'(csr_chan.index))
            CSR_TRIM_LOW:  trim_low_in  = csr_chan.data;
            CSR_TRIM_HIGH: trim_high_in = csr_chan.data;
            default: begin
               trim_low_in  = trim_low_ff;
               trim_high_in = trim_high_ff;
            end
         endcase
      end
      gain_y_in = gain_y_f(trim_low_in[CodeW-1:0]);
      gain_z_in = gain_z_f(code_z_f(trim_low_in, trim_high_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trim_low_ff  <= '0;
         trim_high_ff <= '0;
         gain_y_ff    <= GainYReset;
         gain_z_ff    <= GainZReset;
      end else begin
         trim_low_ff  <= trim_low_in;
         trim_high_ff <= trim_high_in;
         gain_y_ff    <= gain_y_in;
         gain_z_ff    <= gain_z_in;
      end
   end

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign s1_move        = s1_valid_ff && out_free;
   assign s1_valid_in    = req_accept || (s1_valid_ff && !out_free);
   assign rsp_valid_in   = s1_move || (rsp_valid_ff && !rsp_chan.ready);

   // The offsets are bit flips: X drops 32768, Z drops 65536 from the 17-bit sum.
   always_comb begin
      x_in = $signed({~req_chan.raw_first[RawW-1], ~req_chan.raw_first[RawW-1],
                      req_chan.raw_first[RawW-2:0]});
      y_in = $signed({1'b0, req_chan.raw_second} - {1'b0, req_chan.raw_third});
      z_in = $signed(({1'b0, req_chan.raw_second} + {1'b0, req_chan.raw_third})
                     ^ {1'b1, {RawW{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   mag_comp_scale u_scale_x (.axis(x_ff), .gain(GainX),     .field(scaled_x));
   mag_comp_scale u_scale_y (.axis(y_ff), .gain(gain_y_ff), .field(scaled_y));
   mag_comp_scale u_scale_z (.axis(z_ff), .gain(gain_z_ff), .field(scaled_z));

   always_ff @(posedge clock) begin
      if (s1_move) begin
         field_x_ff <= scaled_x[FieldXW-1:0];
         field_y_ff <= scaled_y;
         field_z_ff <= scaled_z;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.field_x = field_x_ff;
   assign rsp_chan.field_y = field_y_ff;
   assign rsp_chan.field_z = field_z_ff;

   `MC_ASSERT_NEXT(a_accept_fills_s1, req_accept, s1_valid_ff, "accepted word did not reach stage one")
   `MC_ASSERT_NEXT(a_s1_holds, s1_valid_ff && !out_free, s1_valid_ff && $stable(x_ff) && $stable(z_ff), "stalled stage one changed")
   `MC_ASSERT_NEXT(a_move_fills_rsp, s1_move, rsp_valid_ff, "stage one word did not reach the result register")
   `MC_ASSERT_NOW(a_gain_y_match, 1'b1, gain_y_ff == gain_y_f(trim_low_ff[CodeW-1:0]), "Y gain does not match trim byte")
   `MC_ASSERT_NOW(a_gain_z_match, 1'b1, gain_z_ff == gain_z_f(code_z_f(trim_low_ff, trim_high_ff)), "Z gain does not match trim bytes")

endmodule

// ===== src/mag_comp_scale.sv =====
// Gain multiply and divide by 1024 with truncation toward zero for one axis.
`timescale 1ns / 1ps

module mag_comp_scale
   import mag_comp_pkg::*;
(
   input  logic signed [AxisW-1:0]  axis,
   input  logic        [GainW-1:0]  gain,
   output logic signed [FieldW-1:0] field
);

   logic signed [ProdW-1:0] prod;
   logic signed [ProdW-1:0] biased;
   logic signed [ProdW-1:0] quot;

   // A negative product is biased by 1023 so the arithmetic shift rounds toward zero.
   always_comb begin
      prod   = ProdW'(axis) * $signed({{(ProdW-GainW){1'b0}}, gain});
      biased = prod[ProdW-1] ? (prod + 40'sd1023) : prod;
      quot   = biased >>> DivShift;
      field  = quot[FieldW-1:0];
   end

endmodule
